### rtl/core/two_finger_gesture_detector_assert.svh
// Assertion macros for the two-finger gesture detector checker.
// Plain text macros only; no package or module dependencies.
`ifndef TWO_FINGER_GESTURE_DETECTOR_ASSERT_SVH
`define TWO_FINGER_GESTURE_DETECTOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TFGD_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("two_finger_gesture_detector: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define TFGD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("two_finger_gesture_detector: next-cycle check failed");

`endif

### rtl/core/tfgd_pkg.sv
// Shared types and constants of the two-finger gesture detector.
// No dependencies; used by the top level and its checker.
`default_nettype none

package tfgd_pkg;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int ZOOM_W     = 17;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE = 1'd1;

	localparam logic [CFG_DATA_W-1:0] MIN_INTERVAL_RST = 16'd13;
	localparam logic [CFG_DATA_W-1:0] MIN_DISTANCE_RST = 16'd25;

	localparam logic [1:0] ZOOM_NONE   = 2'd0;
	localparam logic [1:0] ZOOM_GROW   = 2'd1;
	localparam logic [1:0] ZOOM_SHRINK = 2'd2;

	localparam logic [1:0] ROT_NONE = 2'd0;
	localparam logic [1:0] ROT_CW   = 2'd1;
	localparam logic [1:0] ROT_ACW  = 2'd2;

	typedef struct packed {
		logic        action;
		logic [15:0] x_pos;
		logic [15:0] y_pos;
		logic [31:0] time_ms;
	} in_word_t;

	typedef struct packed {
		logic              gesture_active;
		logic [1:0]        zoom_dir;
		logic [ZOOM_W-1:0] zoom_amount;
		logic [1:0]        rotate_dir;
	} out_word_t;

endpackage

`default_nettype wire

### rtl/core/two_finger_gesture_detector.sv
// Two-finger gesture detector: top level with bit-serial squaring and square root.
// Depends on tfgd_pkg for the word types, register indices and result codes.
// A press or release word goes from idle straight to the result state. A move word
// is accepted, squared in the shift-and-add squaring unit (it stops as soon as both
// differences have been shifted out, and the squares are summed in its last step),
// rooted in the two-bit-per-step square root, and then decided and loaded into the
// output register. One word is processed at a time; a new word is taken while the
// previous result still waits in the output register, but the result stage waits
// for that register to drain. Configuration writes take effect at once.
`default_nettype none

module two_finger_gesture_detector #(
	parameter int COORD_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  tfgd_pkg::in_word_t                  in_word,
	output logic                                out_valid,
	input  logic                                out_stall,
	output tfgd_pkg::out_word_t                 out_word,
	input  logic                                cfg_we,
	input  logic [tfgd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tfgd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int CB = COORD_BITS;
	localparam int PW = 2 * CB;
	localparam int SW = 2 * CB + 1;
	localparam int ZW = tfgd_pkg::ZOOM_W;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_ROOT = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t state_q;

	logic          two_finger_q;
	logic [CB-1:0] prev_x_q, prev_y_q, anchor_x_q, anchor_y_q;
	logic [ZW-1:0] prev_dist_q;
	logic [31:0]   last_time_q;
	logic [15:0]   min_interval_q, min_distance_q;
	logic          move_q, time_ok_q;
	logic          out_valid_q;

	logic [CB-1:0] mplier_x_q, mplier_y_q;
	logic [PW-1:0] mcand_x_q, mcand_y_q, sq_x_q, sq_y_q;
	logic [SW-1:0] rem_q, root_q, bit_q;
	tfgd_pkg::out_word_t out_word_q;

	logic          in_accept, out_free, take, time_ok_in, y_up;
	logic [CB-1:0] x_in, y_in, ref_x, ref_y, dx_in, dy_in;
	logic [31:0]   dt_in;
	logic [SW-1:0] trial;
	logic [ZW-1:0] dist_root, min_dist_z, half_dist_z;
	logic          fin_tf, fin_set_dist;
	logic [1:0]    fin_rot;
	tfgd_pkg::out_word_t fin_word;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;
	assign out_free  = !out_valid_q || !out_stall;

	// The reference point is the anchor during a gesture, else the last report.
	assign x_in  = in_word.x_pos[CB-1:0];
	assign y_in  = in_word.y_pos[CB-1:0];
	assign ref_x = two_finger_q ? anchor_x_q : prev_x_q;
	assign ref_y = two_finger_q ? anchor_y_q : prev_y_q;
	assign dx_in = (x_in > ref_x) ? (x_in - ref_x) : (ref_x - x_in);
	assign dy_in = (y_in > ref_y) ? (y_in - ref_y) : (ref_y - y_in);
	assign dt_in = in_word.time_ms - last_time_q;
	assign time_ok_in = (dt_in < 32'(min_interval_q));

	assign trial = root_q + bit_q;
	assign take  = (rem_q >= trial);

	assign dist_root   = ZW'(root_q[CB:0]);
	assign min_dist_z  = ZW'(min_distance_q);
	assign half_dist_z = ZW'(min_distance_q >> 1);

	// By the result stage, prev_x_q and prev_y_q already hold the new point.
	assign y_up = (prev_y_q > anchor_y_q);
	always_comb begin
		if (anchor_x_q > prev_x_q) begin
			fin_rot = y_up ? tfgd_pkg::ROT_ACW : tfgd_pkg::ROT_CW;
		end else begin
			fin_rot = y_up ? tfgd_pkg::ROT_CW : tfgd_pkg::ROT_ACW;
		end
	end

	always_comb begin
		fin_word     = '0;
		fin_tf       = two_finger_q;
		fin_set_dist = 1'b0;
		if (move_q) begin
			if (!two_finger_q) begin
				if (time_ok_q && (dist_root > min_dist_z)) begin
					fin_tf                  = 1'b1;
					fin_set_dist            = 1'b1;
					fin_word.gesture_active = 1'b1;
				end
			end else if (dist_root < half_dist_z) begin
				fin_tf = 1'b0;
			end else begin
				fin_set_dist            = 1'b1;
				fin_word.gesture_active = 1'b1;
				fin_word.rotate_dir     = fin_rot;
				if (dist_root > prev_dist_q) begin
					fin_word.zoom_dir    = tfgd_pkg::ZOOM_GROW;
					fin_word.zoom_amount = dist_root - prev_dist_q;
				end else begin
					fin_word.zoom_dir    = tfgd_pkg::ZOOM_SHRINK;
					fin_word.zoom_amount = prev_dist_q - dist_root;
				end
			end
		end
	end

	// Control and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			two_finger_q   <= 1'b0;
			prev_x_q       <= '0;
			prev_y_q       <= '0;
			anchor_x_q     <= '0;
			anchor_y_q     <= '0;
			prev_dist_q    <= '0;
			last_time_q    <= '0;
			min_interval_q <= tfgd_pkg::MIN_INTERVAL_RST;
			min_distance_q <= tfgd_pkg::MIN_DISTANCE_RST;
			move_q         <= 1'b0;
			time_ok_q      <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					tfgd_pkg::CFG_MIN_INTERVAL: min_interval_q <= cfg_data;
					tfgd_pkg::CFG_MIN_DISTANCE: min_distance_q <= cfg_data;
					default: ;
				endcase
			end

			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						move_q      <= in_word.action;
						time_ok_q   <= time_ok_in;
						prev_x_q    <= x_in;
						prev_y_q    <= y_in;
						last_time_q <= in_word.time_ms;
						// Outside a gesture the anchor is free to follow the last point.
						if (!two_finger_q) begin
							anchor_x_q <= prev_x_q;
							anchor_y_q <= prev_y_q;
						end
						if (in_word.action) begin
							state_q <= ST_MUL;
						end else begin
							two_finger_q <= 1'b0;
							state_q      <= ST_FIN;
						end
					end
				end
				ST_MUL: begin
					if ((mplier_x_q == '0) && (mplier_y_q == '0)) begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (bit_q[0]) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						two_finger_q <= fin_tf;
						if (fin_set_dist) begin
							prev_dist_q <= dist_root;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath: shift-and-add squares, then a restoring square root.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			mplier_x_q <= dx_in;
			mplier_y_q <= dy_in;
			mcand_x_q  <= PW'(dx_in);
			mcand_y_q  <= PW'(dy_in);
			sq_x_q     <= '0;
			sq_y_q     <= '0;
		end else if (state_q == ST_MUL) begin
			if ((mplier_x_q == '0) && (mplier_y_q == '0)) begin
				rem_q  <= SW'(sq_x_q) + SW'(sq_y_q);
				root_q <= '0;
				bit_q  <= {1'b1, {PW{1'b0}}};
			end else begin
				if (mplier_x_q[0]) begin
					sq_x_q <= sq_x_q + mcand_x_q;
				end
				if (mplier_y_q[0]) begin
					sq_y_q <= sq_y_q + mcand_y_q;
				end
				mplier_x_q <= mplier_x_q >> 1;
				mplier_y_q <= mplier_y_q >> 1;
				mcand_x_q  <= mcand_x_q << 1;
				mcand_y_q  <= mcand_y_q << 1;
			end
		end else if (state_q == ST_ROOT) begin
			if (take) begin
				rem_q  <= rem_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && out_free) begin
			out_word_q <= fin_word;
		end
	end

endmodule

`default_nettype wire

### rtl/core/tfgd_checker.sv
// Port-level checker for the two-finger gesture detector, bound to the top level.
// Depends on tfgd_pkg and the assertion macros in two_finger_gesture_detector_assert.svh.
`default_nettype none
`include "two_finger_gesture_detector_assert.svh"

module tfgd_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_stall,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire tfgd_pkg::out_word_t out_word
);

	logic in_take, out_hold, word_idle, word_busy;
	logic zoom_none, rot_none, zoom_known, idle_clean, busy_codes;

	assign in_take    = in_valid && !in_stall;
	assign out_hold   = out_valid && out_stall;
	assign word_idle  = out_valid && !out_word.gesture_active;
	assign word_busy  = out_valid && out_word.gesture_active;
	assign zoom_none  = (out_word.zoom_dir == tfgd_pkg::ZOOM_NONE);
	assign rot_none   = (out_word.rotate_dir == tfgd_pkg::ROT_NONE);
	assign zoom_known = zoom_none || (out_word.zoom_dir == tfgd_pkg::ZOOM_GROW) ||
			(out_word.zoom_dir == tfgd_pkg::ZOOM_SHRINK);
	assign idle_clean = zoom_none && rot_none && (out_word.zoom_amount == '0);
	assign busy_codes = (zoom_none == rot_none) && zoom_known &&
			(!zoom_none || (out_word.zoom_amount == '0));

	// Only one word is in flight, so an accepted word closes the input at once.
	`TFGD_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_take, in_stall)

	`TFGD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_hold, out_valid && $stable(out_word))

	// A word outside a gesture carries no zoom and no rotation.
	`TFGD_ASSERT_HOLDS(a_idle_word_clean, clk, arst_n, word_idle, idle_clean)

	// A gesture start has neither zoom nor rotation; an operation has both.
	`TFGD_ASSERT_HOLDS(a_active_word_codes, clk, arst_n, word_busy, busy_codes)

endmodule

bind two_finger_gesture_detector tfgd_checker u_tfgd_checker (.*);

`default_nettype wire
